/* hdl/hef_pkg.sv */
// Shared types and constants for the Ethernet header field extractor.
package hef_pkg;

    localparam logic [15:0] ETYPE_IPV4   = 16'h0800;
    localparam logic [15:0] ETYPE_ARP    = 16'h0806;
    localparam logic [7:0]  PROTO_TCP    = 8'd6;
    localparam logic [7:0]  PROTO_UDP    = 8'd17;
    localparam logic [15:0] ETH_HDR_LEN  = 16'd14;
    localparam logic [15:0] IPV4_MIN_END = 16'd34;
    localparam logic [15:0] TCP_HDR_LEN  = 16'd20;
    localparam logic [15:0] UDP_HDR_LEN  = 16'd8;
    localparam logic [15:0] POS_MAX      = 16'hFFFF;

    localparam logic [2:0] CLS_OTHER = 3'd0;
    localparam logic [2:0] CLS_ARP   = 3'd1;
    localparam logic [2:0] CLS_IPV4  = 3'd2;
    localparam logic [2:0] CLS_TCP   = 3'd3;
    localparam logic [2:0] CLS_UDP   = 3'd4;

    typedef struct packed {
        logic [15:0] position;
        logic [47:0] dst_mac;
        logic [47:0] src_mac;
        logic [15:0] eth_type;
        logic [3:0]  header_words;
        logic [7:0]  ip_protocol;
        logic [31:0] addr0;
        logic [31:0] addr1;
        logic [15:0] port0;
        logic [15:0] port1;
    } t_frame_fields;

endpackage

/* hdl/ethernet_header_field_extractor_top.sv */
// Top level of the Ethernet header field extractor.
// A final byte is held in the input register, then loads the result register.
// Throughput: one frame byte per cycle; the input register stalls only when a
// final byte meets a result register still held by the consumer.
// Reset: synchronous active-low i_rst_n empties both registers and clears the
// byte counter and all captured header fields.
module ethernet_header_field_extractor_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [47:0] o_dst_mac,
    output logic [47:0] o_src_mac,
    output logic [15:0] o_eth_type,
    output logic [2:0]  o_protocol_class,
    output logic [31:0] o_src_ip,
    output logic [31:0] o_dest_ip,
    output logic [15:0] o_src_port,
    output logic [15:0] o_dst_port,
    output logic        o_ports_valid,
    output logic [15:0] o_frame_bytes,
    output logic        o_parse_ok
);

    logic                   r_in_valid;
    logic [7:0]             r_byte;
    logic                   r_last;
    logic                   out_free;
    logic                   advance;
    hef_pkg::t_frame_fields fields;

    // advance the held byte unless it ends a frame and the result slot is busy
    assign advance = r_in_valid && (!r_last || out_free);
    assign o_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_frame_byte;
            r_last <= i_last_byte;
        end
    end

    hef_frame_state u_frame (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (advance),
        .i_last   (r_last),
        .i_byte   (r_byte),
        .o_fields (fields)
    );

    hef_record u_record (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_load           (advance && r_last),
        .i_fields         (fields),
        .i_ready          (i_ready),
        .o_free           (out_free),
        .o_valid          (o_valid),
        .o_dst_mac        (o_dst_mac),
        .o_src_mac        (o_src_mac),
        .o_eth_type       (o_eth_type),
        .o_protocol_class (o_protocol_class),
        .o_src_ip         (o_src_ip),
        .o_dest_ip        (o_dest_ip),
        .o_src_port       (o_src_port),
        .o_dst_port       (o_dst_port),
        .o_ports_valid    (o_ports_valid),
        .o_frame_bytes    (o_frame_bytes),
        .o_parse_ok       (o_parse_ok)
    );

endmodule

/* hdl/hef_frame_state.sv */
// Per-frame field capture: byte counter and header field registers.
module hef_frame_state (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_take,
    input  logic                  i_last,
    input  logic [7:0]            i_byte,
    output hef_pkg::t_frame_fields o_fields
);

    hef_pkg::t_frame_fields r_frame;
    hef_pkg::t_frame_fields n_frame;

    always_comb begin
        logic [15:0] pos;
        logic [3:0]  hw_eff;
        logic [6:0]  l4;
        logic [15:0] l4_off;
        pos     = r_frame.position;
        n_frame = r_frame;
        n_frame.position = (pos == hef_pkg::POS_MAX) ? pos : pos + 16'd1;

        for (int i = 0; i < 6; i++) begin
            if (pos == 16'(i)) n_frame.dst_mac[8*(5-i) +: 8] = i_byte;
            if (pos == 16'(i + 6)) n_frame.src_mac[8*(5-i) +: 8] = i_byte;
        end
        if (pos == 16'd12) n_frame.eth_type[15:8] = i_byte;
        if (pos == 16'd13) n_frame.eth_type[7:0] = i_byte;

        hw_eff = (pos == hef_pkg::ETH_HDR_LEN) ? i_byte[3:0] : r_frame.header_words;
        l4     = 7'd14 + {1'b0, hw_eff, 2'b00};
        l4_off = pos - {9'd0, l4};

        if (r_frame.eth_type == hef_pkg::ETYPE_ARP && pos >= hef_pkg::ETH_HDR_LEN) begin
            for (int i = 0; i < 4; i++) begin
                if (pos == 16'(28 + i)) n_frame.addr0[8*(3-i) +: 8] = i_byte;
                if (pos == 16'(38 + i)) n_frame.addr1[8*(3-i) +: 8] = i_byte;
            end
        end else if (r_frame.eth_type == hef_pkg::ETYPE_IPV4
                     && pos >= hef_pkg::ETH_HDR_LEN) begin
            n_frame.header_words = hw_eff;
            if (pos == 16'd23) n_frame.ip_protocol = i_byte;
            for (int i = 0; i < 4; i++) begin
                if (pos == 16'(26 + i)) n_frame.addr0[8*(3-i) +: 8] = i_byte;
                if (pos == 16'(30 + i)) n_frame.addr1[8*(3-i) +: 8] = i_byte;
            end
            // first four bytes of the L4 header hold the two ports
            if (pos >= {9'd0, l4} && l4_off < 16'd4) begin
                unique case (l4_off[1:0])
                    2'd0: n_frame.port0[15:8] = i_byte;
                    2'd1: n_frame.port0[7:0]  = i_byte;
                    2'd2: n_frame.port1[15:8] = i_byte;
                    2'd3: n_frame.port1[7:0]  = i_byte;
                    default: n_frame.port1[7:0] = i_byte;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_last)) begin
            r_frame <= '0;
        end else if (i_take) begin
            r_frame <= n_frame;
        end
    end

    assign o_fields = n_frame;

endmodule

/* hdl/hef_record.sv */
// Frame classification and the result register with its handshake.
module hef_record (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  hef_pkg::t_frame_fields i_fields,
    input  logic                   i_ready,
    output logic                   o_free,
    output logic                   o_valid,
    output logic [47:0]            o_dst_mac,
    output logic [47:0]            o_src_mac,
    output logic [15:0]            o_eth_type,
    output logic [2:0]             o_protocol_class,
    output logic [31:0]            o_src_ip,
    output logic [31:0]            o_dest_ip,
    output logic [15:0]            o_src_port,
    output logic [15:0]            o_dst_port,
    output logic                   o_ports_valid,
    output logic [15:0]            o_frame_bytes,
    output logic                   o_parse_ok
);

    logic        r_valid;
    logic [2:0]  n_cls;
    logic [31:0] n_sip;
    logic [31:0] n_dip;
    logic [15:0] n_sp;
    logic [15:0] n_dp;
    logic        n_pv;
    logic        n_ok;

    always_comb begin
        logic [15:0] plen;
        logic [15:0] hlen;
        plen  = i_fields.position - hef_pkg::ETH_HDR_LEN;
        hlen  = {10'd0, i_fields.header_words, 2'b00};
        n_cls = hef_pkg::CLS_OTHER;
        n_sip = '0;
        n_dip = '0;
        n_sp  = '0;
        n_dp  = '0;
        n_pv  = 1'b0;
        n_ok  = 1'b1;
        if (i_fields.eth_type == hef_pkg::ETYPE_ARP) begin
            n_cls = hef_pkg::CLS_ARP;
            n_sip = i_fields.addr0;
            n_dip = i_fields.addr1;
        end else if (i_fields.eth_type == hef_pkg::ETYPE_IPV4) begin
            n_cls = hef_pkg::CLS_IPV4;
            if (i_fields.position < hef_pkg::IPV4_MIN_END) begin
                n_ok = 1'b0;
            end else begin
                n_sip = i_fields.addr0;
                n_dip = i_fields.addr1;
                if (i_fields.ip_protocol == hef_pkg::PROTO_TCP) begin
                    n_cls = hef_pkg::CLS_TCP;
                    n_pv  = (plen >= hlen + hef_pkg::TCP_HDR_LEN);
                end else if (i_fields.ip_protocol == hef_pkg::PROTO_UDP) begin
                    n_cls = hef_pkg::CLS_UDP;
                    n_pv  = (plen >= hlen + hef_pkg::UDP_HDR_LEN);
                end
                if (n_pv) begin
                    n_sp = i_fields.port0;
                    n_dp = i_fields.port1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            o_dst_mac        <= i_fields.dst_mac;
            o_src_mac        <= i_fields.src_mac;
            o_eth_type       <= i_fields.eth_type;
            o_protocol_class <= n_cls;
            o_src_ip         <= n_sip;
            o_dest_ip        <= n_dip;
            o_src_port       <= n_sp;
            o_dst_port       <= n_dp;
            o_ports_valid    <= n_pv;
            o_frame_bytes    <= i_fields.position;
            o_parse_ok       <= n_ok;
        end
    end

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;

endmodule

/* hdl/hef_checker.sv */
// Port-level checker for the Ethernet header field extractor, with its bind.
module hef_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [15:0] o_eth_type,
    input logic [2:0]  o_protocol_class,
    input logic [31:0] o_src_ip,
    input logic [15:0] o_src_port,
    input logic [15:0] o_dst_port,
    input logic        o_ports_valid,
    input logic        o_parse_ok
);

    // hold a stalled request
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_protocol_class) && $stable(o_src_ip))
        else $error("result changed while stalled");

    a_ports_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_ports_valid |->
            (o_protocol_class == hef_pkg::CLS_TCP || o_protocol_class == hef_pkg::CLS_UDP))
        else $error("ports valid outside TCP or UDP");

    a_short_ipv4: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_parse_ok |->
            o_protocol_class == hef_pkg::CLS_IPV4 && o_src_ip == '0 && !o_ports_valid)
        else $error("short IPv4 record not cleared");

    a_arp_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_protocol_class == hef_pkg::CLS_ARP |-> o_eth_type == hef_pkg::ETYPE_ARP)
        else $error("ARP class with wrong ethertype");

    a_port_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_ports_valid |-> o_src_port == '0 && o_dst_port == '0)
        else $error("ports not zero when invalid");

endmodule

bind ethernet_header_field_extractor_top hef_checker u_hef_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_eth_type       (o_eth_type),
    .o_protocol_class (o_protocol_class),
    .o_src_ip         (o_src_ip),
    .o_src_port       (o_src_port),
    .o_dst_port       (o_dst_port),
    .o_ports_valid    (o_ports_valid),
    .o_parse_ok       (o_parse_ok)
);
